// ===== rtl/u8s_pkg.sv =====
package u8s_pkg;

    // Byte classes
    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_HIGH   = 8'h80;

    // UTF-8 prefix masks and tags
    localparam logic [7:0] MASK_2      = 8'hC0;
    localparam logic [7:0] TAG_CONT    = 8'h80;
    localparam logic [7:0] TAG_LEAD2   = 8'hC0;
    localparam logic [7:0] MASK_3      = 8'hE0;
    localparam logic [7:0] TAG_LEAD3   = 8'hE0;
    localparam logic [7:0] MASK_4      = 8'hF0;
    localparam logic [7:0] TAG_LEAD4   = 8'hF0;
    localparam logic [7:0] MASK_5      = 8'hF8;

    localparam int          CAP_W       = 13;
    localparam int          COUNT_W     = 12;
    localparam logic [12:0] CAP_RESET   = 13'd512;
    localparam logic [12:0] COUNT_LIMIT = 13'd4096;

    // Results of one input byte, left aligned: first byte in [31:24]
    typedef struct packed {
        logic [31:0]        bytes;
        logic [2:0]         n;
        logic               done;
        logic [COUNT_W-1:0] cnt;
    } step_res_t;

endpackage

// ===== rtl/u8s_if.sv =====
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8s_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_done;
    logic [11:0] out_count;

    modport source (output valid, output out_byte, output out_valid, output out_done,
                    output out_count, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_done,
                    input out_count, output ready);
endinterface

// ===== rtl/utf8_text_sanitizer_top.sv =====
// Channel  Dir  Payload                                    Handshake
// din      in   in_byte[7:0]                               valid/ready
// dout     out  out_byte[7:0] out_valid out_done           valid/ready
//               out_count[11:0]
// cfg      in   cfg_wdata[12:0] (out_capacity)             cfg_we, no back-pressure
//
// One byte enters per cycle unless stalled. It waits in an input register,
// is decoded by u8s_step and its results (0 to 4) land in a burst register
// that drains one result per cycle while dout is ready; ordinary text runs at
// one byte per cycle when dout does not stall.
// Reset (async, active low) clears capacity to 512 and all text state.
// Either side may stall: the input register holds its byte until the burst
// register is empty or its last result leaves in the same cycle.
module utf8_text_sanitizer_top #(
    parameter int MAX_TEXT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    u8s_in_if.sink      din,
    u8s_out_if.source   dout,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);
    import u8s_pkg::*;

    // clip of the capacity that follows from the text size
    localparam logic [CAP_W-1:0] LIM_CAP =
        (MAX_TEXT < 4096) ? CAP_W'(MAX_TEXT) : COUNT_LIMIT;

    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   lim;

    logic [7:0]         in_byte_reg;
    logic               in_vld_reg;

    logic [31:0]        bur_bytes_reg;
    logic [2:0]         bur_n_reg;
    logic               bur_done_reg;
    logic [COUNT_W-1:0] bur_cnt_reg;

    logic               advance;
    logic               out_fire;
    step_res_t          res;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    assign lim = (cap_reg > LIM_CAP) ? LIM_CAP : cap_reg;

    // burst may take a new set when empty or when its last result leaves now
    assign out_fire = dout.valid && dout.ready;
    assign advance  = in_vld_reg &&
                      (bur_n_reg == 3'd0 || (bur_n_reg == 3'd1 && dout.ready));
    assign din.ready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (din.valid && din.ready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
            in_byte_reg <= din.in_byte;
    end

    u8s_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .byte_in (in_byte_reg),
        .lim     (lim),
        .res     (res)
    );

    // burst register: count of results is control, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bur_n_reg <= 3'd0;
        else if (advance)
            bur_n_reg <= res.n;
        else if (out_fire)
            bur_n_reg <= bur_n_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bur_bytes_reg <= res.bytes;
            bur_done_reg  <= res.done;
            bur_cnt_reg   <= res.cnt;
        end
        else if (out_fire)
        begin
            bur_bytes_reg <= {bur_bytes_reg[23:0], 8'd0};
            bur_cnt_reg   <= bur_cnt_reg + 12'd1;
        end
    end

    assign dout.valid     = (bur_n_reg != 3'd0);
    assign dout.out_byte  = bur_bytes_reg[31:24];
    assign dout.out_valid = !bur_done_reg;
    assign dout.out_done  = bur_done_reg;
    assign dout.out_count = bur_cnt_reg;

    // closing result is always alone in its burst
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (bur_n_reg != 3'd0 && bur_done_reg) |-> bur_n_reg == 3'd1)
        else $error("closing result shares a burst");

    // a written byte never reaches the terminator slot
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !bur_done_reg) |-> ({1'b0, bur_cnt_reg} < lim))
        else $error("byte count at or beyond capacity");

    // a held byte is not lost while the burst side is busy
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("input register lost its byte");

    // burst never holds more than one UTF-8 sequence
    a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
        bur_n_reg <= 3'd4)
        else $error("burst overfull");

endmodule

// ===== rtl/u8s_step.sv =====
module u8s_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    input  logic [12:0]         lim,
    output u8s_pkg::step_res_t  res
);
    import u8s_pkg::*;

    logic [23:0]        pend_reg, pend_next;
    logic [2:0]         need_reg, need_next;
    logic [1:0]         have_reg, have_next;
    logic [COUNT_W-1:0] wc_reg, wc_next;
    logic               lws_reg, lws_next;
    logic               halt_reg, halt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            need_reg <= '0;
            have_reg <= '0;
            wc_reg   <= '0;
            lws_reg  <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (fire)
        begin
            pend_reg <= pend_next;
            need_reg <= need_next;
            have_reg <= have_next;
            wc_reg   <= wc_next;
            lws_reg  <= lws_next;
            halt_reg <= halt_next;
        end
    end

    always_comb
    begin
        logic        fresh;
        logic        is_cont;
        logic [12:0] sum_seq;
        logic [12:0] sum_one;

        fresh   = 1'b1;
        is_cont = (byte_in & MASK_2) == TAG_CONT;
        sum_seq = {1'b0, wc_reg} + 13'(need_reg);
        sum_one = {1'b0, wc_reg} + 13'd1;

        pend_next = pend_reg;
        need_next = need_reg;
        have_next = have_reg;
        wc_next   = wc_reg;
        lws_next  = lws_reg;
        halt_next = halt_reg;

        res.bytes = '0;
        res.n     = 3'd0;
        res.done  = 1'b0;
        res.cnt   = wc_reg + 12'd1;

        if (byte_in == BYTE_NUL)
        begin
            // closing result, then a clean slate for the next text
            res.n     = 3'd1;
            res.done  = 1'b1;
            res.cnt   = wc_reg;
            pend_next = '0;
            need_next = '0;
            have_next = '0;
            wc_next   = '0;
            lws_next  = 1'b0;
            halt_next = 1'b0;
        end
        else if (!halt_reg)
        begin
            if (need_reg != 3'd0)
            begin
                pend_next = '0;
                need_next = '0;
                have_next = '0;
                if (is_cont)
                begin
                    fresh = 1'b0;
                    if (({1'b0, have_reg} + 3'd1) < need_reg)
                    begin
                        pend_next = {pend_reg[15:0], byte_in};
                        need_next = need_reg;
                        have_next = have_reg + 2'd1;
                    end
                    else if (sum_seq >= lim)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        res.n     = need_reg;
                        res.bytes = {pend_reg, byte_in} << (6'(4 - need_reg) * 6'd8);
                        wc_next   = sum_seq[COUNT_W-1:0];
                        lws_next  = 1'b0;
                    end
                end
            end

            if (fresh)
            begin
                if (sum_one >= lim)
                begin
                    halt_next = 1'b1;
                end
                else if (byte_in == BYTE_TAB || byte_in == BYTE_LF || byte_in == BYTE_CR)
                begin
                    if (!lws_reg)
                    begin
                        res.n     = 3'd1;
                        res.bytes = {BYTE_SPACE, 24'd0};
                        wc_next   = sum_one[COUNT_W-1:0];
                        lws_next  = 1'b1;
                    end
                end
                else if (byte_in < BYTE_SPACE)
                begin
                    // other control bytes dropped
                end
                else if (byte_in < BYTE_HIGH)
                begin
                    res.n     = 3'd1;
                    res.bytes = {byte_in, 24'd0};
                    wc_next   = sum_one[COUNT_W-1:0];
                    lws_next  = (byte_in == BYTE_SPACE);
                end
                else if ((byte_in & MASK_3) == TAG_LEAD2)
                begin
                    need_next = 3'd2;
                    pend_next = {16'd0, byte_in};
                    have_next = 2'd1;
                end
                else if ((byte_in & MASK_4) == TAG_LEAD3)
                begin
                    need_next = 3'd3;
                    pend_next = {16'd0, byte_in};
                    have_next = 2'd1;
                end
                else if ((byte_in & MASK_5) == TAG_LEAD4)
                begin
                    need_next = 3'd4;
                    pend_next = {16'd0, byte_in};
                    have_next = 2'd1;
                end
            end
        end
    end

endmodule
